/* rtl/core/mcfc_pkg.sv */
`timescale 1ns / 1ps

package mcfc_pkg;

    // Fixed field widths of the item and result words.
    localparam int DATA_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int OUT_SHIFT  = 29;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // Operation codes of an input word.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_TAPS  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TX    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RX    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DELAY = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN  = 3'd4;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FLUSH,
        S_MERGE
    } t_state;

    // States of the merging stage.
    typedef enum logic [2:0] {
        M_IDLE,
        M_SUM,
        M_MUL,
        M_FIN,
        M_PUSH
    } t_mstate;

    // Per-cycle control broadcast to every lane.
    typedef struct packed {
        logic clear;
        logic valid;
    } t_step;

    // Status reported by the merging stage.
    typedef struct packed {
        logic busy;
    } t_mstatus;

endpackage

/* rtl/core/mcfc_hist.sv */
`timescale 1ns / 1ps

module mcfc_hist
    import mcfc_pkg::*;
#(
    parameter int HIST = 32,
    parameter int HW   = 5
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [HW-1:0]            i_waddr,
    input  logic signed [DATA_W-1:0] i_wre,
    input  logic signed [DATA_W-1:0] i_wim,
    input  logic [HW-1:0]            i_raddr,
    output logic signed [DATA_W-1:0] o_rre,
    output logic signed [DATA_W-1:0] o_rim
);

    logic [2*DATA_W-1:0] r_mem [HIST];
    logic [2*DATA_W-1:0] r_rdata;

    // One write port for the pushed sample, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wre, i_wim};
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rre = $signed(r_rdata[2*DATA_W-1:DATA_W]);
    assign o_rim = $signed(r_rdata[DATA_W-1:0]);

endmodule

/* rtl/core/mcfc_lane.sv */
`timescale 1ns / 1ps

module mcfc_lane
    import mcfc_pkg::*;
#(
    parameter int MAX_TAPS = 16,
    parameter int TAW      = 4,
    parameter int ACC_W    = 38
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_tap_we,
    input  logic [TAW-1:0]           i_tap_waddr,
    input  logic signed [DATA_W-1:0] i_tap_re,
    input  logic signed [DATA_W-1:0] i_tap_im,
    input  logic [TAW-1:0]           i_tap_raddr,
    input  t_step                    i_step,
    input  logic signed [DATA_W-1:0] i_x_re,
    input  logic signed [DATA_W-1:0] i_x_im,
    output logic signed [ACC_W-1:0]  o_acc_re,
    output logic signed [ACC_W-1:0]  o_acc_im
);

    localparam int PW = 2 * DATA_W;

    logic [2*DATA_W-1:0]     r_tap_mem [MAX_TAPS];
    logic [2*DATA_W-1:0]     r_tap_rd;
    logic                    r_v1;
    logic                    r_v2;
    logic signed [PW-1:0]    r_p_rr;
    logic signed [PW-1:0]    r_p_ii;
    logic signed [PW-1:0]    r_p_ri;
    logic signed [PW-1:0]    r_p_ir;
    logic signed [ACC_W-1:0] r_acc_re;
    logic signed [ACC_W-1:0] r_acc_im;
    logic signed [DATA_W-1:0] h_re;
    logic signed [DATA_W-1:0] h_im;

    // Tap store of this antenna pair with a registered read.
    always_ff @(posedge i_clk) begin
        if (i_tap_we) begin
            r_tap_mem[i_tap_waddr] <= {i_tap_re, i_tap_im};
        end
        r_tap_rd <= r_tap_mem[i_tap_raddr];
    end

    assign h_re = $signed(r_tap_rd[2*DATA_W-1:DATA_W]);
    assign h_im = $signed(r_tap_rd[DATA_W-1:0]);

    // Valid bits follow the read and product stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_step.valid;
            r_v2 <= r_v1;
        end
    end

    // Four real products of the complex multiply, registered.
    always_ff @(posedge i_clk) begin
        r_p_rr <= i_x_re * h_re;
        r_p_ii <= i_x_im * h_im;
        r_p_ri <= i_x_im * h_re;
        r_p_ir <= i_x_re * h_im;
    end

    // Accumulate one complex term per valid step.
    always_ff @(posedge i_clk) begin
        if (i_step.clear) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_v2) begin
            r_acc_re <= r_acc_re + {{(ACC_W-PW){r_p_rr[PW-1]}}, r_p_rr}
                                 - {{(ACC_W-PW){r_p_ii[PW-1]}}, r_p_ii};
            r_acc_im <= r_acc_im + {{(ACC_W-PW){r_p_ri[PW-1]}}, r_p_ri}
                                 + {{(ACC_W-PW){r_p_ir[PW-1]}}, r_p_ir};
        end
    end

    assign o_acc_re = r_acc_re;
    assign o_acc_im = r_acc_im;

endmodule

/* rtl/core/mcfc_merge.sv */
`timescale 1ns / 1ps

module mcfc_merge
    import mcfc_pkg::*;
#(
    parameter int NB_TX = 2,
    parameter int NB_RX = 2,
    parameter int TXW   = 2,
    parameter int RXW   = 2,
    parameter int ACC_W = 38
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [ACC_W-1:0]  i_acc_re [NB_RX][NB_TX],
    input  logic signed [ACC_W-1:0]  i_acc_im [NB_RX][NB_TX],
    input  logic [TXW-1:0]           i_ntx,
    input  logic [RXW-1:0]           i_nrx,
    input  logic [GAIN_W-1:0]        i_gain,
    output t_mstatus                 o_status,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_rx_index,
    output logic signed [DATA_W-1:0] o_rx_re,
    output logic signed [DATA_W-1:0] o_rx_im,
    output logic                     o_last
);

    localparam int RIW  = (NB_RX > 1) ? $clog2(NB_RX) : 1;
    localparam int SUM_W = ACC_W + 2;
    localparam int LO_W = SUM_W / 2;
    localparam int HI_W = SUM_W - LO_W;
    localparam int PH_W = HI_W + GAIN_W + 1;
    localparam int PL_W = LO_W + GAIN_W + 1;
    localparam int PW   = SUM_W + GAIN_W + 1;
    localparam logic signed [PW-1:0] RND   = PW'(64'sd1 <<< (OUT_SHIFT - 1));
    localparam logic signed [PW-1:0] Q_MAX = PW'((64'sd1 <<< (DATA_W - 1)) - 1);
    localparam logic signed [PW-1:0] Q_MIN = -Q_MAX - 1;

    t_mstate r_state;
    t_mstate n_state;
    logic [RXW-1:0]           r_r;
    logic signed [SUM_W-1:0]  r_sum_re;
    logic signed [SUM_W-1:0]  r_sum_im;
    logic signed [SUM_W-1:0]  sum_re;
    logic signed [SUM_W-1:0]  sum_im;
    logic signed [PH_W-1:0]   r_ph_re;
    logic signed [PH_W-1:0]   r_ph_im;
    logic signed [PL_W-1:0]   r_pl_re;
    logic signed [PL_W-1:0]   r_pl_im;
    logic signed [DATA_W-1:0] r_res_re;
    logic signed [DATA_W-1:0] r_res_im;
    logic signed [DATA_W-1:0] fin_re;
    logic signed [DATA_W-1:0] fin_im;
    logic                     r_out_valid;
    logic                     r_out_idx;
    logic signed [DATA_W-1:0] r_out_re;
    logic signed [DATA_W-1:0] r_out_im;
    logic                     r_out_last;
    logic                     out_free;
    logic                     is_last;
    logic signed [GAIN_W:0]   gain_s;

    // Rounds half up, shifts down and saturates one scaled sum.
    function automatic logic signed [DATA_W-1:0] round_sat(
        input logic signed [PH_W-1:0] ph,
        input logic signed [PL_W-1:0] pl
    );
        logic signed [PW-1:0] t;
        logic signed [PW-1:0] q;
        t = (PW'(ph) <<< LO_W) + PW'(pl) + RND;
        q = t >>> OUT_SHIFT;
        if (q > Q_MAX) begin
            q = Q_MAX;
        end else if (q < Q_MIN) begin
            q = Q_MIN;
        end
        return q[DATA_W-1:0];
    endfunction

    assign gain_s   = $signed({1'b0, i_gain});
    assign out_free = !r_out_valid || i_out_ready;
    assign is_last  = ({1'b0, r_r} + 1'b1) == {1'b0, i_nrx};

    // Sum of the lanes of the current receive antenna over transmit antennas in use.
    always_comb begin
        sum_re = '0;
        sum_im = '0;
        for (int j = 0; j < NB_TX; j++) begin
            if (j < int'(i_ntx)) begin
                sum_re = sum_re + SUM_W'(i_acc_re[r_r[RIW-1:0]][j]);
                sum_im = sum_im + SUM_W'(i_acc_im[r_r[RIW-1:0]][j]);
            end
        end
    end

    assign fin_re = round_sat(r_ph_re, r_pl_re);
    assign fin_im = round_sat(r_ph_im, r_pl_im);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: one receive antenna per pass through sum, multiply, finish, push.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            M_IDLE: begin
                if (i_start && (i_nrx != '0)) begin
                    n_state = M_SUM;
                end
            end
            M_SUM:  n_state = M_MUL;
            M_MUL:  n_state = M_FIN;
            M_FIN:  n_state = M_PUSH;
            M_PUSH: begin
                if (out_free) begin
                    n_state = is_last ? M_IDLE : M_SUM;
                end
            end
            default: n_state = M_IDLE;
        endcase
    end

    // Antenna counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r <= '0;
        end else if (r_state == M_IDLE) begin
            r_r <= '0;
        end else if (r_state == M_PUSH && out_free) begin
            r_r <= r_r + 1'b1;
        end
    end

    // Datapath registers: lane sum, gain partial products, finished result.
    always_ff @(posedge i_clk) begin
        if (r_state == M_SUM) begin
            r_sum_re <= sum_re;
            r_sum_im <= sum_im;
        end
        if (r_state == M_MUL) begin
            r_ph_re <= $signed(r_sum_re[SUM_W-1:LO_W]) * gain_s;
            r_ph_im <= $signed(r_sum_im[SUM_W-1:LO_W]) * gain_s;
            r_pl_re <= $signed({1'b0, r_sum_re[LO_W-1:0]}) * gain_s;
            r_pl_im <= $signed({1'b0, r_sum_im[LO_W-1:0]}) * gain_s;
        end
        if (r_state == M_FIN) begin
            r_res_re <= fin_re;
            r_res_im <= fin_im;
        end
    end

    // Output register parts the merge from the result consumer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == M_PUSH && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == M_PUSH && out_free) begin
            r_out_idx  <= r_r[0];
            r_out_re   <= r_res_re;
            r_out_im   <= r_res_im;
            r_out_last <= is_last;
        end
    end

    assign o_status.busy = (r_state != M_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_rx_index    = r_out_idx;
    assign o_rx_re       = r_out_re;
    assign o_rx_im       = r_out_im;
    assign o_last        = r_out_last;

endmodule

/* rtl/core/mimo_complex_fir_channel_core.sv */
`timescale 1ns / 1ps

// MIMO complex FIR channel emulator. A load word (operation 1) writes one
// complex tap. A sample word pushes one complex sample per transmit antenna
// into the history and then produces one result word per receive antenna in
// use, the last one flagged. One lane per antenna pair walks the taps, one
// complex multiply-accumulate per cycle, so a sample word holds the input
// through the tap walk, the pipeline drain and one pass of the merging stage
// per receive antenna (longer while the output is stalled), then the return
// to idle. Configuration is written through i_cfg_we, i_cfg_addr and
// i_cfg_wdata only while the block is idle: the user keeps to this, the block
// itself does not enforce it. No clearing pass runs after reset.
module mimo_complex_fir_channel_core
    import mcfc_pkg::*;
#(
    parameter int NB_TX     = 2,
    parameter int NB_RX     = 2,
    parameter int MAX_TAPS  = 16,
    parameter int MAX_DELAY = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_operation,
    input  logic                     i_block_start,
    input  logic signed [DATA_W-1:0] i_tx0_re,
    input  logic signed [DATA_W-1:0] i_tx0_im,
    input  logic signed [DATA_W-1:0] i_tx1_re,
    input  logic signed [DATA_W-1:0] i_tx1_im,
    input  logic                     i_tap_tx,
    input  logic                     i_tap_rx,
    input  logic [3:0]               i_tap_index,
    input  logic signed [DATA_W-1:0] i_tap_re,
    input  logic signed [DATA_W-1:0] i_tap_im,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_rx_index,
    output logic signed [DATA_W-1:0] o_rx_re,
    output logic signed [DATA_W-1:0] o_rx_im,
    output logic                     o_last
);

    localparam int HIST  = MAX_DELAY + MAX_TAPS;
    localparam int HW    = (HIST > 1) ? $clog2(HIST) : 1;
    localparam int SW    = $clog2(HIST + 1);
    localparam int TW    = $clog2(MAX_TAPS + 1);
    localparam int TAW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int DW    = (MAX_DELAY > 0) ? $clog2(MAX_DELAY + 1) : 1;
    localparam int TXW   = $clog2(NB_TX + 1);
    localparam int RXW   = $clog2(NB_RX + 1);
    localparam int ACC_W = 2 * DATA_W + 2 + TAW;
    localparam int DDW   = SW + 1;

    // Configuration registers.
    logic [4:0]        r_taps;
    logic [1:0]        r_txn;
    logic [1:0]        r_rxn;
    logic [4:0]        r_dly;
    logic [GAIN_W-1:0] r_gain;

    // Sequencer and history bookkeeping.
    t_state         r_state;
    t_state         n_state;
    logic [HW-1:0]  r_ptr;
    logic [SW-1:0]  r_seen;
    logic [HW-1:0]  r_rd;
    logic [HW-1:0]  n_rd;
    logic [TW-1:0]  r_l;
    logic [1:0]     r_fl;

    logic [TW-1:0]  ntaps;
    logic [TXW-1:0] ntx;
    logic [RXW-1:0] nrx;
    logic [DW-1:0]  dly;
    logic           accept;
    logic           acc_sample;
    logic           acc_load;
    logic [DDW-1:0] dd;
    logic           walk_end;
    logic           m_start;
    t_step          step;
    t_mstatus       m_status;
    logic           load_ok;

    logic signed [DATA_W-1:0] x_re [NB_TX];
    logic signed [DATA_W-1:0] x_im [NB_TX];
    logic signed [ACC_W-1:0]  acc_re [NB_RX][NB_TX];
    logic signed [ACC_W-1:0]  acc_im [NB_RX][NB_TX];

    // Register writes; indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps <= 5'd16;
            r_txn  <= 2'd2;
            r_rxn  <= 2'd2;
            r_dly  <= 5'd0;
            r_gain <= 16'd16384;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_TAPS:  r_taps <= i_cfg_wdata[4:0];
                REG_TX:    r_txn  <= i_cfg_wdata[1:0];
                REG_RX:    r_rxn  <= i_cfg_wdata[1:0];
                REG_DELAY: r_dly  <= i_cfg_wdata[4:0];
                REG_GAIN:  r_gain <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Registers above their maximum saturate to it.
    assign ntaps = (int'(r_taps) > MAX_TAPS) ? TW'(MAX_TAPS) : TW'(r_taps);
    assign ntx   = (int'(r_txn) > NB_TX) ? TXW'(NB_TX) : TXW'(r_txn);
    assign nrx   = (int'(r_rxn) > NB_RX) ? RXW'(NB_RX) : RXW'(r_rxn);
    assign dly   = (int'(r_dly) > MAX_DELAY) ? DW'(MAX_DELAY) : DW'(r_dly);

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign acc_sample = accept && (i_operation == OP_SAMPLE);
    assign acc_load   = accept && (i_operation == OP_LOAD);
    assign load_ok    = (int'(i_tap_index) < MAX_TAPS);

    // Delay of the tap being walked and the end of the walk.
    assign dd       = DDW'(dly) + DDW'(r_l);
    assign walk_end = ({1'b0, r_l} + 1'b1) >= {1'b0, ntaps};

    // Start of the read walk: the newest sample less the delay.
    always_comb begin
        if (int'(r_ptr) >= int'(dly)) begin
            n_rd = HW'(int'(r_ptr) - int'(dly));
        end else begin
            n_rd = HW'(int'(r_ptr) + HIST - int'(dly));
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and lane control.
    always_comb begin
        n_state    = r_state;
        step.clear = acc_sample;
        step.valid = 1'b0;
        m_start    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (acc_sample) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                step.valid = (r_l < ntaps) && (dd < DDW'(r_seen));
                if (walk_end) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (r_fl == 2'd2) begin
                    m_start = 1'b1;
                    n_state = S_MERGE;
                end
            end
            S_MERGE: begin
                if (!m_status.busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // History pointer, fill count and walk counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_seen <= '0;
            r_rd   <= '0;
            r_l    <= '0;
            r_fl   <= '0;
        end else begin
            if (acc_sample) begin
                r_ptr <= (int'(r_ptr) == HIST - 1) ? '0 : r_ptr + 1'b1;
                if (i_block_start) begin
                    r_seen <= SW'(1);
                end else if (int'(r_seen) < HIST) begin
                    r_seen <= r_seen + 1'b1;
                end
                r_rd <= n_rd;
                r_l  <= '0;
                r_fl <= '0;
            end
            if (r_state == S_WALK) begin
                r_rd <= (r_rd == '0) ? HW'(HIST - 1) : r_rd - 1'b1;
                r_l  <= r_l + 1'b1;
            end
            if (r_state == S_FLUSH) begin
                r_fl <= r_fl + 1'b1;
            end
        end
    end

    // Transmit antennas beyond the two input fields see zero samples.
    always_comb begin
        for (int j = 0; j < NB_TX; j++) begin
            x_re[j] = '0;
            x_im[j] = '0;
        end
        x_re[0] = i_tx0_re;
        x_im[0] = i_tx0_im;
        if (NB_TX > 1) begin
            x_re[NB_TX > 1 ? 1 : 0] = i_tx1_re;
            x_im[NB_TX > 1 ? 1 : 0] = i_tx1_im;
        end
    end

    // One history memory per transmit antenna, one lane per antenna pair.
    for (genvar j = 0; j < NB_TX; j++) begin : g_tx
        logic signed [DATA_W-1:0] h_re;
        logic signed [DATA_W-1:0] h_im;

        mcfc_hist #(
            .HIST (HIST),
            .HW   (HW)
        ) u_hist (
            .i_clk   (i_clk),
            .i_we    (acc_sample),
            .i_waddr (r_ptr),
            .i_wre   (x_re[j]),
            .i_wim   (x_im[j]),
            .i_raddr (r_rd),
            .o_rre   (h_re),
            .o_rim   (h_im)
        );

        for (genvar r = 0; r < NB_RX; r++) begin : g_rx
            logic tap_we;

            assign tap_we = acc_load && load_ok
                         && (int'(i_tap_tx) == j) && (int'(i_tap_rx) == r);

            mcfc_lane #(
                .MAX_TAPS (MAX_TAPS),
                .TAW      (TAW),
                .ACC_W    (ACC_W)
            ) u_lane (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_tap_we    (tap_we),
                .i_tap_waddr (TAW'(i_tap_index)),
                .i_tap_re    (i_tap_re),
                .i_tap_im    (i_tap_im),
                .i_tap_raddr (TAW'(r_l)),
                .i_step      (step),
                .i_x_re      (h_re),
                .i_x_im      (h_im),
                .o_acc_re    (acc_re[r][j]),
                .o_acc_im    (acc_im[r][j])
            );
        end
    end

    // Combine lanes per receive antenna, scale, round and hand out.
    mcfc_merge #(
        .NB_TX (NB_TX),
        .NB_RX (NB_RX),
        .TXW   (TXW),
        .RXW   (RXW),
        .ACC_W (ACC_W)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (m_start),
        .i_acc_re    (acc_re),
        .i_acc_im    (acc_im),
        .i_ntx       (ntx),
        .i_nrx       (nrx),
        .i_gain      (r_gain),
        .o_status    (m_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_rx_index  (o_rx_index),
        .o_rx_re     (o_rx_re),
        .o_rx_im     (o_rx_im),
        .o_last      (o_last)
    );

endmodule
